// ===== hw/rtl/mpid_pkg.sv =====
// ----------------------------------------------------------------------------
// mpid_pkg
// Shared types, codes and saturation helpers for the multichannel PID unit.
// ----------------------------------------------------------------------------
package mpid_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    // Gains are Q8.24, so a gain*value product carries 24 extra fraction bits.
    localparam int FRAC_W = 24;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int SUM_W  = TERM_W + 2;

    localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [DATA_W-1:0] MAX_Q16 = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] MIN_Q16 = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SEL_KP     = 3'd0,
        SEL_KI     = 3'd1,
        SEL_KD     = 3'd2,
        SEL_LOW    = 3'd3,
        SEL_HIGH   = 3'd4,
        SEL_TARGET = 3'd5
    } t_sel;

    // One accepted input word.
    typedef struct packed {
        logic [1:0]               op;
        logic [2:0]               ch;
        logic [2:0]               sel;
        logic signed [DATA_W-1:0] value;
    } t_item;

    // Operands handed from the channel state stage to the multiply stage.
    typedef struct packed {
        logic [2:0]               ch;
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic signed [DATA_W-1:0] kd;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] integ;
        logic signed [DATA_W-1:0] diff;
        logic                     sat;
    } t_ops;

    // Saturate a 33-bit two's complement sum to 32 bits.
    function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) begin
            return v[DATA_W] ? MIN_Q16 : MAX_Q16;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic ovf33(input logic [DATA_W:0] v);
        return v[DATA_W] != v[DATA_W-1];
    endfunction

endpackage

// ===== hw/rtl/mpid_chan_state.sv =====
// ----------------------------------------------------------------------------
// mpid_chan_state
// Per-channel coefficient and integrator state with the error, clamp and
// difference logic of the first stage.
// ----------------------------------------------------------------------------
module mpid_chan_state #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mpid_pkg::t_item i_item,
    input  logic            i_fire,
    output mpid_pkg::t_ops  o_ops,
    output logic            o_is_result
);
    import mpid_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic signed [DATA_W-1:0] r_kp     [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_ki     [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_kd     [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_low    [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_high   [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_target [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_integ  [NUM_CHANNELS];
    logic signed [DATA_W-1:0] r_last   [NUM_CHANNELS];

    logic [IDX_W-1:0]         w_idx;
    logic                     w_in_range;
    logic [DATA_W:0]          w_err_raw;
    logic [DATA_W:0]          w_isum_raw;
    logic [DATA_W:0]          w_diff_raw;
    logic signed [DATA_W-1:0] w_err;
    logic signed [DATA_W-1:0] w_isum;
    logic signed [DATA_W-1:0] w_lo_clamp;
    logic signed [DATA_W-1:0] w_integ;
    logic signed [DATA_W-1:0] w_diff;
    logic signed [DATA_W-1:0] w_low;
    logic signed [DATA_W-1:0] w_high;

    assign w_idx      = IDX_W'(i_item.ch);
    assign w_in_range = (9'(i_item.ch) < 9'(NUM_CHANNELS));
    assign w_low      = r_low[w_idx];
    assign w_high     = r_high[w_idx];

    always_comb begin
        w_err_raw  = {r_target[w_idx][DATA_W-1], r_target[w_idx]}
                   - {i_item.value[DATA_W-1], i_item.value};
        w_err      = sat33(w_err_raw);
        w_isum_raw = {r_integ[w_idx][DATA_W-1], r_integ[w_idx]} + {w_err[DATA_W-1], w_err};
        w_isum     = sat33(w_isum_raw);
        // Anti-windup: low limit first, then high limit wins.
        w_lo_clamp = (w_isum < w_low) ? w_low : w_isum;
        w_integ    = (w_lo_clamp > w_high) ? w_high : w_lo_clamp;
        w_diff_raw = {w_err[DATA_W-1], w_err} - {r_last[w_idx][DATA_W-1], r_last[w_idx]};
        w_diff     = sat33(w_diff_raw);
    end

    always_comb begin
        o_ops.ch    = i_item.ch;
        o_ops.kp    = r_kp[w_idx];
        o_ops.ki    = r_ki[w_idx];
        o_ops.kd    = r_kd[w_idx];
        o_ops.err   = w_err;
        o_ops.integ = w_integ;
        o_ops.diff  = w_diff;
        o_ops.sat   = ovf33(w_err_raw) | ovf33(w_isum_raw) | ovf33(w_diff_raw);
    end

    assign o_is_result = (i_item.op == OP_SAMPLE) && w_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_kp[i]     <= '0;
                r_ki[i]     <= '0;
                r_kd[i]     <= '0;
                r_low[i]    <= '0;
                r_high[i]   <= ONE_Q16;
                r_target[i] <= '0;
                r_integ[i]  <= '0;
                r_last[i]   <= '0;
            end
        end else if (i_fire) begin
            if (i_item.op == OP_CLEAR) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_integ[i] <= '0;
                    r_last[i]  <= '0;
                end
            end else if (w_in_range && i_item.op == OP_WRITE) begin
                unique case (i_item.sel)
                    SEL_KP:     r_kp[w_idx]     <= i_item.value;
                    SEL_KI:     r_ki[w_idx]     <= i_item.value;
                    SEL_KD:     r_kd[w_idx]     <= i_item.value;
                    SEL_LOW:    r_low[w_idx]    <= i_item.value;
                    SEL_HIGH:   r_high[w_idx]   <= i_item.value;
                    SEL_TARGET: r_target[w_idx] <= i_item.value;
                    default: begin
                    end
                endcase
            end else if (w_in_range && i_item.op == OP_SAMPLE) begin
                r_integ[w_idx] <= w_integ;
                r_last[w_idx]  <= w_err;
            end
        end
    end

    // A clear leaves the first channel's integrator and last error at zero.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && i_fire && i_item.op == OP_CLEAR)
            |-> (r_integ[0] == '0) && (r_last[0] == '0))
        else $error("integrator state not cleared");

    // With ordered limits the clamped integral stays between them.
    a_integ_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_is_result && (w_low <= w_high))
            |-> ((w_integ >= w_low) && (w_integ <= w_high)))
        else $error("clamped integral outside its limits");

    // A sample stores its error as the channel's last error.
    a_last_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && i_fire && o_is_result)
            |-> (r_last[$past(w_idx)] == $past(w_err)))
        else $error("last error not stored");

endmodule

// ===== hw/rtl/multichannel_pid_antiwindup_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_pid_antiwindup_unit
// Per-channel PID regulator with integral clamp, four-register pipeline.
// ----------------------------------------------------------------------------
// Path: a sample word in the input register moves through the operand,
//   product and output registers before its result shows on o_valid.
// Throughput: one word per cycle unless every stage holds a stalled word;
//   stages hold on their own, so bubbles behind a stalled result still fill.
// Reset (synchronous, active low): clears all stage valid bits, zeroes gains,
//   low limits, targets, integrators and last errors, sets high limits to 1.0.
// ----------------------------------------------------------------------------
module multichannel_pid_antiwindup_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_op,
    input  logic [2:0]                         i_channel,
    input  logic [2:0]                         i_coef_select,
    input  logic signed [mpid_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0]                         o_channel_res,
    output logic signed [mpid_pkg::DATA_W-1:0] o_drive,
    output logic                               o_saturated
);
    import mpid_pkg::*;

    // Stage 1: input register. Channel state is read and updated here.
    logic  r_v1;
    t_item r_item;
    // Stage 2: operand register.
    logic  r_v2;
    t_ops  r_ops;
    // Stage 3: product register.
    logic                     r_v3;
    logic [2:0]               r_ch3;
    logic signed [PROD_W-1:0] r_prod_p;
    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_d;
    logic                     r_sat3;
    // Stage 4: output register.
    logic                     r_v4;
    logic [2:0]               r_ch4;
    logic signed [DATA_W-1:0] r_drive;
    logic                     r_sat4;

    logic free1, free2, free3, free4;
    logic w_fire1;
    t_ops w_ops;
    logic w_is_result;

    logic [SUM_W-1:0]  w_sum;
    logic              w_sum_ovf;
    logic [DATA_W-1:0] w_drive;

    // Each register may load when it is empty or its word moves on.
    assign free4   = !r_v4 || i_ready;
    assign free3   = !r_v3 || free4;
    assign free2   = !r_v2 || free3;
    assign free1   = !r_v1 || free2;
    assign o_ready = free1;
    assign w_fire1 = r_v1 && free2;

    mpid_chan_state #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_item),
        .i_fire      (w_fire1),
        .o_ops       (w_ops),
        .o_is_result (w_is_result)
    );

    // Round half up: floor(p / 2^24) plus the bit just below the cut.
    // Sum the three terms exactly, then saturate to 32 bits.
    always_comb begin
        w_sum = SUM_W'($signed(r_prod_p[PROD_W-1:FRAC_W]))
              + SUM_W'($signed(r_prod_i[PROD_W-1:FRAC_W]))
              + SUM_W'($signed(r_prod_d[PROD_W-1:FRAC_W]))
              + SUM_W'(r_prod_p[FRAC_W-1])
              + SUM_W'(r_prod_i[FRAC_W-1])
              + SUM_W'(r_prod_d[FRAC_W-1]);
        w_sum_ovf = !((&w_sum[SUM_W-1:DATA_W-1]) || !(|w_sum[SUM_W-1:DATA_W-1]));
        if (w_sum_ovf) begin
            w_drive = w_sum[SUM_W-1] ? MIN_Q16 : MAX_Q16;
        end else begin
            w_drive = w_sum[DATA_W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1 && w_is_result;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (free4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload registers: advance with their stage, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_item.op    <= i_op;
            r_item.ch    <= i_channel;
            r_item.sel   <= i_coef_select;
            r_item.value <= i_value;
        end
        if (free2) begin
            r_ops <= w_ops;
        end
        if (free3) begin
            r_ch3    <= r_ops.ch;
            r_prod_p <= $signed(r_ops.kp) * $signed(r_ops.err);
            r_prod_i <= $signed(r_ops.ki) * $signed(r_ops.integ);
            r_prod_d <= $signed(r_ops.kd) * $signed(r_ops.diff);
            r_sat3   <= r_ops.sat;
        end
        if (free4) begin
            r_ch4   <= r_ch3;
            r_drive <= w_drive;
            r_sat4  <= r_sat3 | w_sum_ovf;
        end
    end

    assign o_valid       = r_v4;
    assign o_channel_res = r_ch4;
    assign o_drive       = r_drive;
    assign o_saturated   = r_sat4;

    // Input backpressure only when every stage holds a word.
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with an empty stage");

    // Write, clear and ignored words never reach the operand register.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && r_v1 && free2 && !w_is_result) |-> !r_v2)
        else $error("non-sample word produced a result");

    // A taken result with nothing behind it empties the output register.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !r_v3) |=> !o_valid)
        else $error("result delivered twice");

endmodule

// ===== sim/mpid_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpid_checker
// Watches the input and output handshakes of the multichannel PID unit, predicts
// each drive word from its own copy of the channel tables and compares field by field.
// ----------------------------------------------------------------------------
module mpid_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [1:0]                         i_op,
    input  logic [2:0]                         i_channel,
    input  logic [2:0]                         i_coef_select,
    input  logic signed [mpid_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [2:0]                         i_channel_res,
    input  logic signed [mpid_pkg::DATA_W-1:0] i_drive,
    input  logic                               i_saturated,
    output int                                 o_mismatches,
    output int                                 o_outstanding,
    output int                                 o_checked
);
    import mpid_pkg::*;

    typedef struct {
        logic [2:0]               ch;
        logic signed [DATA_W-1:0] drive;
        logic                     sat;
    } t_drive_rec;

    logic signed [DATA_W-1:0] kp_q      [NUM_CHANNELS];
    logic signed [DATA_W-1:0] ki_q      [NUM_CHANNELS];
    logic signed [DATA_W-1:0] kd_q      [NUM_CHANNELS];
    logic signed [DATA_W-1:0] low_q     [NUM_CHANNELS];
    logic signed [DATA_W-1:0] high_q    [NUM_CHANNELS];
    logic signed [DATA_W-1:0] target_q  [NUM_CHANNELS];
    logic signed [DATA_W-1:0] integ_acc [NUM_CHANNELS];
    logic signed [DATA_W-1:0] prev_err  [NUM_CHANNELS];

    t_drive_rec expected_drives[$];
    int mismatch_n = 0;
    int checked_n  = 0;

    function automatic logic signed [DATA_W-1:0] clip32(input longint v, inout logic flag);
        if (v > longint'(32'sh7fff_ffff)) begin
            flag = 1'b1;
            return MAX_Q16;
        end
        if (v < -longint'(64'sd2147483648)) begin
            flag = 1'b1;
            return MIN_Q16;
        end
        return v[DATA_W-1:0];
    endfunction

    // Q8.24 gain times Q16.16 value, rounded half up back to Q16.16.
    function automatic longint gain_product(input logic signed [DATA_W-1:0] g,
                                            input logic signed [DATA_W-1:0] x);
        return (longint'(g) * longint'(x) + 64'sd8388608) >>> FRAC_W;
    endfunction

    function automatic t_drive_rec step_sample(input logic [2:0] ch,
                                               input logic signed [DATA_W-1:0] meas);
        t_drive_rec               r;
        logic                     flag;
        logic signed [DATA_W-1:0] err;
        logic signed [DATA_W-1:0] integ;
        logic signed [DATA_W-1:0] diff;
        longint                   total;
        flag  = 1'b0;
        err   = clip32(longint'(target_q[ch]) - longint'(meas), flag);
        integ = clip32(longint'(integ_acc[ch]) + longint'(err), flag);
        // Clamp low first, then high: crossed limits end at the high limit.
        if (integ < low_q[ch]) integ = low_q[ch];
        if (integ > high_q[ch]) integ = high_q[ch];
        integ_acc[ch] = integ;
        diff  = clip32(longint'(err) - longint'(prev_err[ch]), flag);
        total = gain_product(kp_q[ch], err) + gain_product(ki_q[ch], integ)
              + gain_product(kd_q[ch], diff);
        r.drive = clip32(total, flag);
        prev_err[ch] = err;
        r.ch  = ch;
        r.sat = flag;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_drive_rec want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                kp_q[c]      = '0;
                ki_q[c]      = '0;
                kd_q[c]      = '0;
                low_q[c]     = '0;
                high_q[c]    = ONE_Q16;
                target_q[c]  = '0;
                integ_acc[c] = '0;
                prev_err[c]  = '0;
            end
            expected_drives.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked_n++;
                if (expected_drives.size() == 0) begin
                    $display("%0t: unexpected drive word ch=%0d drive=%h sat=%b",
                             $time, i_channel_res, i_drive, i_saturated);
                    mismatch_n++;
                end else begin
                    want = expected_drives.pop_front();
                    if (i_channel_res !== want.ch) begin
                        $display("%0t: channel mismatch: expected %0d, actual %0d",
                                 $time, want.ch, i_channel_res);
                        mismatch_n++;
                    end
                    if (i_drive !== want.drive) begin
                        $display("%0t: drive mismatch on ch %0d: expected %h, actual %h",
                                 $time, want.ch, want.drive, i_drive);
                        mismatch_n++;
                    end
                    if (i_saturated !== want.sat) begin
                        $display("%0t: saturated mismatch on ch %0d: expected %b, actual %b",
                                 $time, want.ch, want.sat, i_saturated);
                        mismatch_n++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_CLEAR) begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        integ_acc[c] = '0;
                        prev_err[c]  = '0;
                    end
                end else if (int'(i_channel) < NUM_CHANNELS) begin
                    if (i_op == OP_WRITE) begin
                        case (i_coef_select)
                            SEL_KP:     kp_q[i_channel]     = i_value;
                            SEL_KI:     ki_q[i_channel]     = i_value;
                            SEL_KD:     kd_q[i_channel]     = i_value;
                            SEL_LOW:    low_q[i_channel]    = i_value;
                            SEL_HIGH:   high_q[i_channel]   = i_value;
                            SEL_TARGET: target_q[i_channel] = i_value;
                            default: ;
                        endcase
                    end else if (i_op == OP_SAMPLE) begin
                        expected_drives.push_back(step_sample(i_channel, i_value));
                    end
                end
            end
        end
        o_outstanding <= expected_drives.size();
        o_mismatches  <= mismatch_n;
        o_checked     <= checked_n;
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random words into the multichannel PID unit under three
// idle/stall mixes; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import mpid_pkg::*;

    // Codes the block has no name for: they must be ignored.
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] SEL_SPARE6 = 3'd6;
    localparam logic [2:0] SEL_SPARE7 = 3'd7;

    // Slowest correct run stays far below this.
    localparam int CYCLE_LIMIT = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               op;
    logic [2:0]               channel;
    logic [2:0]               coef_select;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [2:0]               channel_res;
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;

    int mismatches;
    int outstanding;
    int checked;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int idle_pct  = 18;
    int stall_pct = 81;

    int n_samples  = 0;
    int n_writes   = 0;
    int n_clears   = 0;
    int n_ignored  = 0;
    int cycle_count = 0;

    multichannel_pid_antiwindup_unit #(
        .NUM_CHANNELS(8)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_op          (op),
        .i_channel     (channel),
        .i_coef_select (coef_select),
        .i_value       (value),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_channel_res (channel_res),
        .o_drive       (drive),
        .o_saturated   (saturated)
    );

    mpid_checker #(
        .NUM_CHANNELS(8)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_op          (op),
        .i_channel     (channel),
        .i_coef_select (coef_select),
        .i_value       (value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_channel_res (channel_res),
        .i_drive       (drive),
        .i_saturated   (saturated),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: stall at random, at the rate the current phase asks for.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d drive words still expected",
                     cycle_count, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Words that change state or give a result; ignored words do not count.
    function automatic int effective_words();
        return n_samples + n_writes + n_clears;
    endfunction

    // Present one word and hold it until accepted. Idle cycles go first, so
    // valid is only ever lowered or raised once per edge.
    task automatic send_word(input logic [1:0] w_op, input logic [2:0] w_ch,
                             input logic [2:0] w_sel, input logic [DATA_W-1:0] w_val);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w_op;
        channel     <= w_ch;
        coef_select <= w_sel;
        value       <= w_val;
        do @(posedge clk); while (!in_ready);
        if (w_op == OP_SAMPLE) n_samples++;
        else if (w_op == OP_CLEAR) n_clears++;
        else if (w_op == OP_WRITE && w_sel <= SEL_TARGET) n_writes++;
        else n_ignored++;
    endtask

    // Hold off until every expected drive word has come back. Lower valid and step
    // past a clock edge first so the count includes the word accepted last.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Mostly plausible Q16.16 samples, with full-range words and extremes mixed in.
    function automatic logic [DATA_W-1:0] sample_value();
        case ($urandom_range(9))
            0: return $urandom;
            1: return ($urandom_range(1)) ? MAX_Q16 : MIN_Q16;
            default: return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
        endcase
    endfunction

    // Coefficient words shaped by what they select; gains stay around +-2.0.
    function automatic logic [DATA_W-1:0] coef_value(input logic [2:0] sel);
        if ($urandom_range(7) == 0) return $urandom;
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(2))
                0: return MAX_Q16;
                1: return MIN_Q16;
                default: return '0;
            endcase
        end
        case (sel)
            SEL_LOW:    return -int'($urandom_range(0, 40 * 65536));
            SEL_HIGH:   return int'($urandom_range(0, 40 * 65536));
            SEL_TARGET: return int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
            default:    return int'($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
    endfunction

    // Bursts: load a few coefficients of one channel, then run samples on it.
    // A share of pure noise words hits unknown ops and selects.
    task automatic run_random(input int quota);
        int          goal;
        logic [2:0]  ch;
        logic [2:0]  sel;
        goal = effective_words() + quota;
        while (effective_words() < goal) begin
            ch = 3'($urandom_range(7));
            if ($urandom_range(99) < 12) begin
                send_word(2'($urandom_range(3)), ch, 3'($urandom_range(7)), $urandom);
            end else begin
                if ($urandom_range(99) < 3)
                    send_word(OP_CLEAR, ch, 3'($urandom_range(7)), $urandom);
                repeat ($urandom_range(0, 4)) begin
                    sel = 3'($urandom_range(5));
                    send_word(OP_WRITE, ch, sel, coef_value(sel));
                end
                repeat ($urandom_range(2, 10)) begin
                    // Now and then interleave a sample for another channel.
                    if ($urandom_range(9) == 0)
                        send_word(OP_SAMPLE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                                  sample_value());
                    else
                        send_word(OP_SAMPLE, ch, 3'($urandom_range(7)), sample_value());
                end
            end
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_SAMPLE;
        channel     <= '0;
        coef_select <= SEL_KP;
        value       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed words ----
        // Reset tables: zero gains give a zero drive.
        send_word(OP_SAMPLE, 3'd0, SEL_KP, 32'h0000_0000);
        // Channel 1: plain PID with limits at +-2.0 and target 1.5.
        send_word(OP_WRITE, 3'd1, SEL_KP, 32'h0100_0000);
        send_word(OP_WRITE, 3'd1, SEL_KI, 32'h0080_0000);
        send_word(OP_WRITE, 3'd1, SEL_KD, 32'h0040_0000);
        send_word(OP_WRITE, 3'd1, SEL_LOW, 32'hfffe_0000);
        send_word(OP_WRITE, 3'd1, SEL_HIGH, 32'h0002_0000);
        send_word(OP_WRITE, 3'd1, SEL_TARGET, 32'h0001_8000);
        send_word(OP_SAMPLE, 3'd1, SEL_KP, 32'h0000_0000);
        // Second sample pushes the integral into the high limit.
        send_word(OP_SAMPLE, 3'd1, SEL_KP, 32'h0000_0000);
        // Error and integral sum saturate at the value extremes.
        send_word(OP_WRITE, 3'd2, SEL_TARGET, MAX_Q16);
        send_word(OP_SAMPLE, 3'd2, SEL_KP, MIN_Q16);
        send_word(OP_SAMPLE, 3'd2, SEL_KP, MIN_Q16);
        // Extreme gains drive the output sum into saturation.
        send_word(OP_WRITE, 3'd3, SEL_KP, MAX_Q16);
        send_word(OP_WRITE, 3'd3, SEL_KI, MIN_Q16);
        send_word(OP_SAMPLE, 3'd3, SEL_KP, MIN_Q16);
        // Crossed limits: low above high, the integral ends at high.
        send_word(OP_WRITE, 3'd4, SEL_LOW, 32'h0003_0000);
        send_word(OP_WRITE, 3'd4, SEL_HIGH, 32'hfffd_0000);
        send_word(OP_WRITE, 3'd4, SEL_KI, 32'h0100_0000);
        send_word(OP_SAMPLE, 3'd4, SEL_KP, 32'h0000_0000);
        // Unknown selects and the unused op must leave the tables alone.
        send_word(OP_WRITE, 3'd5, SEL_SPARE6, 32'h1234_5678);
        send_word(OP_WRITE, 3'd5, SEL_SPARE7, 32'h8765_4321);
        send_word(OP_UNUSED, 3'd5, SEL_KP, 32'h7fff_0000);
        send_word(OP_SAMPLE, 3'd5, SEL_KP, 32'h0001_0000);
        // Clear, then channel 1 starts again from a zero integral.
        send_word(OP_CLEAR, 3'd0, SEL_KP, 32'h0000_0000);
        send_word(OP_SAMPLE, 3'd1, SEL_KP, 32'h0000_0000);
        // Derivative difference saturates on a full-swing step.
        send_word(OP_WRITE, 3'd6, SEL_KD, MAX_Q16);
        send_word(OP_SAMPLE, 3'd6, SEL_KP, MAX_Q16);
        send_word(OP_SAMPLE, 3'd6, SEL_KP, MIN_Q16);
        send_word(OP_SAMPLE, 3'd7, SEL_TARGET, 32'hffff_ffff);

        // ---- Random phases ----
        run_random(470);
        // Let the pipeline drain completely once mid-run.
        wait_drained();
        idle_pct  = 81;
        stall_pct = 18;
        run_random(470);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(460);

        wait_drained();
        // Give a stray extra word the time to show up.
        repeat (16) @(posedge clk);

        $display("Covered %0d words: %0d samples, %0d coefficient writes, %0d clears, %0d ignored.",
                 effective_words() + n_ignored, n_samples, n_writes, n_clears, n_ignored);
        $display("Compared %0d drive words under three sender/receiver pacing mixes.", checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
